>>> hdl/pcpf_pkg.sv
// Shared types, widths and constants of the plane contact penalty force block.
package pcpf_pkg;

  localparam int SPATIAL_DIMS = 3;
  localparam int FRAC_BITS    = 16;

  localparam int WORD_W     = 32;
  localparam int GAIN_W     = 31;
  localparam int NORM_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 6 * WORD_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 3 * WORD_W;
  localparam int OUT_USER_W = 3;

  // front: dot products and plane distance
  localparam int PROD_W = NORM_W + WORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int NG_W   = SUM_W - FRAC_BITS;
  localparam int DIST_W = NG_W + 1;

  // back: scale computation
  localparam int MB_W    = GAIN_W + 3;
  localparam int M1_W    = DIST_W + MB_W;
  localparam int S_W     = WORD_W + FRAC_BITS + 2;
  localparam int B_W     = NG_W + 1;
  localparam int SPLIT_W = 18;
  localparam int BHI_W   = B_W - SPLIT_W;
  localparam int PLO_W   = S_W + SPLIT_W + 1;
  localparam int PHI_W   = S_W + BHI_W;
  localparam int FULL_W  = S_W + B_W;
  localparam int CLAMP_W = FULL_W - FRAC_BITS;
  localparam int FIN_W   = S_W + NORM_W;
  localparam int FV_W    = FIN_W - FRAC_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Any scale at or beyond this magnitude clips every output with a non-zero normal.
  localparam logic signed [S_W-1:0] SAT_LIM   = S_W'(1) << (S_W - 2);
  localparam logic signed [B_W-1:0] FIXED_ONE = B_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  typedef enum logic {
    MODE_FORWARD  = 1'b0,
    MODE_BACKWARD = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REGION_NONE = 2'd0,
    REGION_BAND = 2'd1,
    REGION_PEN  = 2'd2
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS    = 3'd0,
    CFG_CUTOFF       = 3'd1,
    CFG_QUAD_GAIN    = 3'd2,
    CFG_NORMAL_X     = 3'd3,
    CFG_NORMAL_Y     = 3'd4,
    CFG_NORMAL_Z     = 3'd5,
    CFG_PLANE_OFFSET = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        stiffness;
    logic [GAIN_W-1:0]        cutoff_distance;
    logic [GAIN_W-1:0]        quad_gain;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic signed [WORD_W-1:0] plane_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stiffness:       GAIN_W'(65536),
    cutoff_distance: GAIN_W'(65536),
    quad_gain:       GAIN_W'(16384),
    normal_x:        '0,
    normal_y:        '0,
    normal_z:        NORM_W'(65536),
    plane_offset:    '0
  };

  // Classified item handed from the front to the back.
  // arg is d - d0 in the band and d otherwise.
  typedef struct packed {
    mode_t                    mode;
    region_t                  region;
    logic signed [DIST_W-1:0] arg;
    logic signed [NG_W-1:0]   ng;
  } item_t;

endpackage

>>> hdl/pcpf_front.sv
// Front end: accepts vertices, forms n.q and n.g, classifies the contact region.
module pcpf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  pcpf_pkg::cfg_t                      cfg,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pcpf_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [pcpf_pkg::IN_USER_W-1:0]      s_tuser,
  input  logic                                q_full,
  output logic                                push,
  output pcpf_pkg::item_t                     item
);

  logic                                     f_adv;
  logic                                     f1_valid;
  pcpf_pkg::mode_t                          f1_mode;
  logic signed [pcpf_pkg::PROD_W-1:0]       fq [3];
  logic signed [pcpf_pkg::PROD_W-1:0]       fg [3];
  logic signed [pcpf_pkg::WORD_W-1:0]       pos [3];
  logic signed [pcpf_pkg::WORD_W-1:0]       grad [3];
  logic signed [pcpf_pkg::NORM_W-1:0]       nrm [3];
  logic signed [pcpf_pkg::SUM_W-1:0]        sum_q;
  logic signed [pcpf_pkg::SUM_W-1:0]        sum_g;
  logic signed [pcpf_pkg::DIST_W-1:0]       plane_d;
  logic signed [pcpf_pkg::DIST_W-1:0]       d0;

  assign f_adv    = !f1_valid || !q_full;
  assign s_tready = f_adv;
  assign push     = f1_valid && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i]  = s_tdata[i * pcpf_pkg::WORD_W +: pcpf_pkg::WORD_W];
      grad[i] = s_tdata[(i + 3) * pcpf_pkg::WORD_W +: pcpf_pkg::WORD_W];
    end
    nrm[0] = cfg.normal_x;
    nrm[1] = cfg.normal_y;
    nrm[2] = cfg.normal_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f_adv) begin
      f1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv && s_tvalid) begin
      f1_mode <= pcpf_pkg::mode_t'(s_tuser[0]);
      for (int i = 0; i < 3; i++) begin
        if (i < pcpf_pkg::SPATIAL_DIMS) begin
          fq[i] <= pcpf_pkg::PROD_W'(nrm[i]) * pcpf_pkg::PROD_W'(pos[i]);
          fg[i] <= pcpf_pkg::PROD_W'(nrm[i]) * pcpf_pkg::PROD_W'(grad[i]);
        end else begin
          fq[i] <= '0;
          fg[i] <= '0;
        end
      end
    end
  end

  // exact sums, one floor at the end
  always_comb begin
    sum_q = pcpf_pkg::SUM_W'(fq[0]) + pcpf_pkg::SUM_W'(fq[1]) + pcpf_pkg::SUM_W'(fq[2]);
    sum_g = pcpf_pkg::SUM_W'(fg[0]) + pcpf_pkg::SUM_W'(fg[1]) + pcpf_pkg::SUM_W'(fg[2]);
    plane_d = pcpf_pkg::DIST_W'($signed(sum_q[pcpf_pkg::SUM_W-1:pcpf_pkg::FRAC_BITS]))
            + pcpf_pkg::DIST_W'(cfg.plane_offset);
    d0    = pcpf_pkg::DIST_W'({1'b0, cfg.cutoff_distance});

    item.mode = f1_mode;
    item.ng   = $signed(sum_g[pcpf_pkg::SUM_W-1:pcpf_pkg::FRAC_BITS]);
    // band edges belong to the band
    priority if (plane_d > d0) begin
      item.region = pcpf_pkg::REGION_NONE;
      item.arg    = plane_d;
    end else if (plane_d < -d0) begin
      item.region = pcpf_pkg::REGION_PEN;
      item.arg    = plane_d;
    end else begin
      item.region = pcpf_pkg::REGION_BAND;
      item.arg    = plane_d - d0;
    end
  end

endmodule

>>> hdl/pcpf_queue.sv
// Short register queue between the classifying front and the arithmetic back.
module pcpf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pcpf_pkg::item_t wr_item,
  input  logic            pop,
  output pcpf_pkg::item_t rd_item,
  output logic            full,
  output logic            empty
);

  pcpf_pkg::item_t                 entries [pcpf_pkg::QUEUE_DEPTH];
  logic [pcpf_pkg::PTR_W-1:0]      wr_ptr;
  logic [pcpf_pkg::PTR_W-1:0]      rd_ptr;
  logic [pcpf_pkg::COUNT_W-1:0]    count;

  assign full    = count == pcpf_pkg::COUNT_W'(pcpf_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == pcpf_pkg::PTR_W'(pcpf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == pcpf_pkg::PTR_W'(pcpf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pcpf_pkg::COUNT_W'(pcpf_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

>>> hdl/pcpf_back.sv
// Back end: scale factor, projection onto the normal and output saturation.
module pcpf_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pcpf_pkg::cfg_t                       cfg,
  input  logic                                 q_valid,
  input  pcpf_pkg::item_t                      q_item,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pcpf_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [pcpf_pkg::OUT_USER_W-1:0]      m_tuser
);

  function automatic logic signed [pcpf_pkg::S_W-1:0] clamp_s(
    input logic signed [pcpf_pkg::CLAMP_W-1:0] v
  );
    logic signed [pcpf_pkg::CLAMP_W-1:0] lim;
    lim = pcpf_pkg::CLAMP_W'(pcpf_pkg::SAT_LIM);
    priority if (v > lim) begin
      clamp_s = pcpf_pkg::SAT_LIM;
    end else if (v < -lim) begin
      clamp_s = -pcpf_pkg::SAT_LIM;
    end else begin
      clamp_s = v[pcpf_pkg::S_W-1:0];
    end
  endfunction

  // {clipped, value}
  function automatic logic [pcpf_pkg::WORD_W:0] clip_word(
    input logic signed [pcpf_pkg::FV_W-1:0] v
  );
    priority if (v > pcpf_pkg::FV_W'(pcpf_pkg::WORD_MAX)) begin
      clip_word = {1'b1, pcpf_pkg::WORD_MAX};
    end else if (v < pcpf_pkg::FV_W'(pcpf_pkg::WORD_MIN)) begin
      clip_word = {1'b1, pcpf_pkg::WORD_MIN};
    end else begin
      clip_word = {1'b0, v[pcpf_pkg::WORD_W-1:0]};
    end
  endfunction

  logic b_adv;
  logic v1, v2, v3, v4, v5, o_valid;

  logic signed [pcpf_pkg::MB_W-1:0]    k_ext;
  logic signed [pcpf_pkg::MB_W-1:0]    neg_k;
  logic signed [pcpf_pkg::MB_W-1:0]    two_g;
  logic signed [pcpf_pkg::MB_W-1:0]    m1_b;

  logic signed [pcpf_pkg::M1_W-1:0]    s1_prod;
  pcpf_pkg::mode_t                     s1_mode;
  pcpf_pkg::region_t                   s1_region;
  logic signed [pcpf_pkg::NG_W-1:0]    s1_ng;

  logic signed [pcpf_pkg::S_W-1:0]     r1;
  logic signed [pcpf_pkg::B_W-1:0]     ng_ext;
  logic signed [pcpf_pkg::B_W-1:0]     g_ext;
  logic signed [pcpf_pkg::S_W-1:0]     a2_next;
  logic signed [pcpf_pkg::B_W-1:0]     b2_next;
  logic signed [pcpf_pkg::S_W-1:0]     s2_a;
  logic signed [pcpf_pkg::B_W-1:0]     s2_b;
  pcpf_pkg::region_t                   s2_region;

  logic signed [pcpf_pkg::PLO_W-1:0]   s3_lo;
  logic signed [pcpf_pkg::PHI_W-1:0]   s3_hi;
  pcpf_pkg::region_t                   s3_region;

  logic signed [pcpf_pkg::FULL_W-1:0]  full;
  logic signed [pcpf_pkg::S_W-1:0]     s4_s;
  pcpf_pkg::region_t                   s4_region;

  logic signed [pcpf_pkg::FIN_W-1:0]   s5_x, s5_y, s5_z;
  pcpf_pkg::region_t                   s5_region;

  logic [pcpf_pkg::WORD_W:0]           cx, cy, cz;
  logic [pcpf_pkg::WORD_W-1:0]         o_x, o_y, o_z;
  pcpf_pkg::region_t                   o_region;
  logic                                o_sat;

  assign b_adv    = !o_valid || m_tready;
  assign pop      = b_adv && q_valid;
  assign m_tvalid = o_valid;
  assign m_tdata  = {o_z, o_y, o_x};
  assign m_tuser  = {o_sat, o_region};

  // first multiply: e*e, 2g*e, -k*d, or zero beyond the cutoff
  always_comb begin
    k_ext = pcpf_pkg::MB_W'(cfg.stiffness);
    neg_k = -k_ext;
    two_g = pcpf_pkg::MB_W'({cfg.quad_gain, 1'b0});
    unique case (q_item.region)
      pcpf_pkg::REGION_BAND: begin
        if (q_item.mode == pcpf_pkg::MODE_BACKWARD) begin
          m1_b = two_g;
        end else begin
          m1_b = q_item.arg[pcpf_pkg::MB_W-1:0];
        end
      end
      pcpf_pkg::REGION_PEN: m1_b = neg_k;
      default:              m1_b = '0;
    endcase
  end

  // second multiply operands; forward penetration passes r1 through times one
  always_comb begin
    r1     = clamp_s(pcpf_pkg::CLAMP_W'($signed(s1_prod[pcpf_pkg::M1_W-1:pcpf_pkg::FRAC_BITS])));
    ng_ext = pcpf_pkg::B_W'(s1_ng);
    g_ext  = pcpf_pkg::B_W'(cfg.quad_gain);
    unique case (s1_region)
      pcpf_pkg::REGION_BAND: begin
        a2_next = r1;
        b2_next = (s1_mode == pcpf_pkg::MODE_BACKWARD) ? ng_ext : g_ext;
      end
      pcpf_pkg::REGION_PEN: begin
        if (s1_mode == pcpf_pkg::MODE_BACKWARD) begin
          a2_next = pcpf_pkg::S_W'(neg_k);
          b2_next = ng_ext;
        end else begin
          a2_next = r1;
          b2_next = pcpf_pkg::FIXED_ONE;
        end
      end
      default: begin
        a2_next = '0;
        b2_next = '0;
      end
    endcase
  end

  always_comb begin
    full = (pcpf_pkg::FULL_W'(s3_hi) <<< pcpf_pkg::SPLIT_W) + pcpf_pkg::FULL_W'(s3_lo);
    cx   = clip_word($signed(s5_x[pcpf_pkg::FIN_W-1:pcpf_pkg::FRAC_BITS]));
    cy   = clip_word($signed(s5_y[pcpf_pkg::FIN_W-1:pcpf_pkg::FRAC_BITS]));
    cz   = clip_word($signed(s5_z[pcpf_pkg::FIN_W-1:pcpf_pkg::FRAC_BITS]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      v5      <= 1'b0;
      o_valid <= 1'b0;
    end else if (b_adv) begin
      v1      <= q_valid;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      v5      <= v4;
      o_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      s1_prod   <= pcpf_pkg::M1_W'(q_item.arg) * pcpf_pkg::M1_W'(m1_b);
      s1_mode   <= q_item.mode;
      s1_region <= q_item.region;
      s1_ng     <= q_item.ng;

      s2_a      <= a2_next;
      s2_b      <= b2_next;
      s2_region <= s1_region;

      // wide product split on the second operand
      s3_lo     <= pcpf_pkg::PLO_W'(s2_a)
                 * pcpf_pkg::PLO_W'($signed({1'b0, s2_b[pcpf_pkg::SPLIT_W-1:0]}));
      s3_hi     <= pcpf_pkg::PHI_W'(s2_a)
                 * pcpf_pkg::PHI_W'($signed(s2_b[pcpf_pkg::B_W-1:pcpf_pkg::SPLIT_W]));
      s3_region <= s2_region;

      s4_s      <= clamp_s($signed(full[pcpf_pkg::FULL_W-1:pcpf_pkg::FRAC_BITS]));
      s4_region <= s3_region;

      s5_x      <= pcpf_pkg::FIN_W'(s4_s) * pcpf_pkg::FIN_W'(cfg.normal_x);
      s5_y      <= pcpf_pkg::FIN_W'(s4_s) * pcpf_pkg::FIN_W'(cfg.normal_y);
      if (pcpf_pkg::SPATIAL_DIMS == 3) begin
        s5_z    <= pcpf_pkg::FIN_W'(s4_s) * pcpf_pkg::FIN_W'(cfg.normal_z);
      end else begin
        s5_z    <= '0;
      end
      s5_region <= s4_region;

      o_x       <= cx[pcpf_pkg::WORD_W-1:0];
      o_y       <= cy[pcpf_pkg::WORD_W-1:0];
      o_z       <= cz[pcpf_pkg::WORD_W-1:0];
      o_sat     <= cx[pcpf_pkg::WORD_W] | cy[pcpf_pkg::WORD_W] | cz[pcpf_pkg::WORD_W];
      o_region  <= s5_region;
    end
  end

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_region == pcpf_pkg::REGION_NONE) |->
      (o_x == '0 && o_y == '0 && o_z == '0 && !o_sat))
    else $error("non-zero result beyond cutoff");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_sat) |->
      (o_x == pcpf_pkg::WORD_MAX || o_x == pcpf_pkg::WORD_MIN ||
       o_y == pcpf_pkg::WORD_MAX || o_y == pcpf_pkg::WORD_MIN ||
       o_z == pcpf_pkg::WORD_MAX || o_z == pcpf_pkg::WORD_MIN))
    else $error("saturated flag without a clipped component");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (!b_adv && v1) |=> (v1 && $stable(s1_prod)))
    else $error("first stage moved during stall");

endmodule

>>> hdl/plane_contact_penalty_force.sv
// Top level of the plane contact penalty force block.
// One vertex per transaction: the block forms d = n.q + offset, classifies it as
// beyond cutoff, quadratic band or linear penetration, and returns either the
// force f(d)*n (mode 0) or the position gradient scale*n*(n.g) (mode 1), Q16.16,
// saturated to 32 bits. It takes one transaction every clock cycle at full rate,
// while the queue is not full. The products are registered at the accepting edge,
// sum and classification are then written into the 4-entry queue, and six back
// stages follow (first multiply, operand select, split wide multiply, recombine and
// clamp, projection on the normal, output clip). Either side may stall independently;
// the queue absorbs it while the back stages hold. Configuration registers are to be
// written only while idle, by the user; the block itself does not enforce it.
module plane_contact_penalty_force (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x, pos_y, pos_z, upstream_x, upstream_y, upstream_z (lowest bits first)
  input  logic [pcpf_pkg::IN_DATA_W-1:0]      s_tdata,
  // mode
  input  logic [pcpf_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_x, out_y, out_z (lowest bits first)
  output logic [pcpf_pkg::OUT_DATA_W-1:0]     m_tdata,
  // contact_region, saturated (lowest bits first)
  output logic [pcpf_pkg::OUT_USER_W-1:0]     m_tuser,
  input  logic                                cfg_we,
  input  logic [pcpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcpf_pkg::WORD_W-1:0]         cfg_data
);

  pcpf_pkg::cfg_t  cfg;
  pcpf_pkg::item_t wr_item;
  pcpf_pkg::item_t rd_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pcpf_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (pcpf_pkg::cfg_reg_t'(cfg_index))
        pcpf_pkg::CFG_STIFFNESS:    cfg.stiffness       <= cfg_data[pcpf_pkg::GAIN_W-1:0];
        pcpf_pkg::CFG_CUTOFF:       cfg.cutoff_distance <= cfg_data[pcpf_pkg::GAIN_W-1:0];
        pcpf_pkg::CFG_QUAD_GAIN:    cfg.quad_gain       <= cfg_data[pcpf_pkg::GAIN_W-1:0];
        pcpf_pkg::CFG_NORMAL_X:     cfg.normal_x        <= cfg_data[pcpf_pkg::NORM_W-1:0];
        pcpf_pkg::CFG_NORMAL_Y:     cfg.normal_y        <= cfg_data[pcpf_pkg::NORM_W-1:0];
        pcpf_pkg::CFG_NORMAL_Z:     cfg.normal_z        <= cfg_data[pcpf_pkg::NORM_W-1:0];
        pcpf_pkg::CFG_PLANE_OFFSET: cfg.plane_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  pcpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .item     (wr_item)
  );

  pcpf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  pcpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (!q_empty),
    .q_item   (rd_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> tb/plane_contact_penalty_force_tb.sv
// Self-checking testbench for the plane contact penalty force block.
module plane_contact_penalty_force_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcpf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;  // no register behind this index
  localparam logic signed [127:0] PROD_CAP = 128'sh4000_0000_0000_0000;
  localparam int PHASES = 8;
  localparam int VERTICES_PER_PHASE = 240;

  typedef struct {
    mode_t                    mode;
    logic signed [WORD_W-1:0] px, py, pz;
    logic signed [WORD_W-1:0] gx, gy, gz;
  } vertex_t;

  typedef struct {
    logic [WORD_W-1:0] fx, fy, fz;
    region_t           region;
    logic              saturated;
  } reaction_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [WORD_W-1:0]     cfg_data = '0;

  cfg_t      plane_cfg = CFG_RESET;
  vertex_t   vertex_q[$];
  reaction_t reaction_q[$];

  logic in_took = 1'b0;
  int   gap_pct = 0;
  int   src_gap = 0;
  int   sink_gap = 0;
  int   mismatches = 0;
  int   vertices_in = 0;
  int   region_count[3] = '{0, 0, 0};
  int   clipped = 0;

  plane_contact_penalty_force u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a*b / 2^FRAC_BITS), clamped to +-2^62
  function automatic longint fixed_mul(input longint a, input longint b);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> FRAC_BITS;
    if (prod > PROD_CAP) prod = PROD_CAP;
    else if (prod < -PROD_CAP) prod = -PROD_CAP;
    return longint'(prod);
  endfunction

  function automatic longint normal_dot(input longint x, input longint y, input longint z);
    longint acc;
    acc = longint'($signed(plane_cfg.normal_x)) * x + longint'($signed(plane_cfg.normal_y)) * y;
    if (SPATIAL_DIMS == 3) acc += longint'($signed(plane_cfg.normal_z)) * z;
    return acc >>> FRAC_BITS;
  endfunction

  function automatic logic [WORD_W-1:0] clip_word(input longint v, inout logic sat);
    if (v > longint'(WORD_MAX)) begin
      sat = 1'b1;
      return WORD_MAX;
    end
    if (v < longint'(WORD_MIN)) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return v[WORD_W-1:0];
  endfunction

  function automatic reaction_t contact_reaction(input vertex_t v);
    reaction_t r;
    longint    d, d0, k, g, e, s;
    logic      sat;
    d0 = longint'(plane_cfg.cutoff_distance);
    k = longint'(plane_cfg.stiffness);
    g = longint'(plane_cfg.quad_gain);
    d = normal_dot(v.px, v.py, v.pz) + longint'($signed(plane_cfg.plane_offset));
    s = 0;
    sat = 1'b0;
    r.region = REGION_NONE;
    if (d >= -d0 && d <= d0) begin
      e = d - d0;
      r.region = REGION_BAND;
      s = (v.mode == MODE_BACKWARD) ? fixed_mul(2 * g, e) : fixed_mul(g, fixed_mul(e, e));
    end else if (d < -d0) begin
      r.region = REGION_PEN;
      s = (v.mode == MODE_BACKWARD) ? -k : fixed_mul(-k, d);
    end
    if (v.mode == MODE_BACKWARD) s = fixed_mul(s, normal_dot(v.gx, v.gy, v.gz));
    r.fx = clip_word(fixed_mul(s, longint'($signed(plane_cfg.normal_x))), sat);
    r.fy = clip_word(fixed_mul(s, longint'($signed(plane_cfg.normal_y))), sat);
    r.fz = '0;
    if (SPATIAL_DIMS == 3)
      r.fz = clip_word(fixed_mul(s, longint'($signed(plane_cfg.normal_z))), sat);
    r.saturated = sat;
    return r;
  endfunction

  // mostly values around the band, some full-range words and some extremes
  function automatic logic [WORD_W-1:0] pick_word(input longint reach);
    longint v;
    int     sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      v = longint'($urandom_range(0, 32'(2 * reach))) - reach;
      return v[WORD_W-1:0];
    end
    if (sel < 85) return $urandom();
    case ($urandom_range(3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_vertex(input mode_t m, input logic [WORD_W-1:0] px, py, pz, gx, gy, gz);
    vertex_t v;
    v.mode = m;
    v.px = px;
    v.py = py;
    v.pz = pz;
    v.gx = gx;
    v.gy = gy;
    v.gz = gz;
    vertex_q.push_back(v);
  endtask

  // writes every register, plus a write to the unused index that must be ignored
  task automatic load_plane(input cfg_t c);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data <= $urandom();
    @(negedge clk);
    cfg_index <= CFG_STIFFNESS;
    cfg_data <= {1'($urandom()), c.stiffness};
    @(negedge clk);
    cfg_index <= CFG_CUTOFF;
    cfg_data <= {1'($urandom()), c.cutoff_distance};
    @(negedge clk);
    cfg_index <= CFG_QUAD_GAIN;
    cfg_data <= {1'($urandom()), c.quad_gain};
    @(negedge clk);
    cfg_index <= CFG_NORMAL_X;
    cfg_data <= {14'($urandom()), c.normal_x};
    @(negedge clk);
    cfg_index <= CFG_NORMAL_Y;
    cfg_data <= {14'($urandom()), c.normal_y};
    @(negedge clk);
    cfg_index <= CFG_NORMAL_Z;
    cfg_data <= {14'($urandom()), c.normal_z};
    @(negedge clk);
    cfg_index <= CFG_PLANE_OFFSET;
    cfg_data <= c.plane_offset;
    @(negedge clk);
    cfg_we <= 1'b0;
    plane_cfg = c;
  endtask

  task automatic drain;
    while (vertex_q.size() != 0 || s_tvalid || reaction_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // source side
  always @(negedge clk) begin : drive_vertices
    vertex_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (vertex_q.size() != 0 && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
        src_gap <= $urandom_range(7);
        s_tvalid <= 1'b0;
      end else if (vertex_q.size() != 0) begin
        nxt = vertex_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {nxt.gz, nxt.gy, nxt.gx, nxt.pz, nxt.py, nxt.px};
        s_tuser <= nxt.mode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      sink_gap <= $urandom_range(7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // check outgoing transaction first, then predict the incoming one
  always @(posedge clk) begin : score
    vertex_t   v;
    reaction_t want, got;
    in_took <= s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got.fx = m_tdata[0 +: WORD_W];
      got.fy = m_tdata[WORD_W +: WORD_W];
      got.fz = m_tdata[2 * WORD_W +: WORD_W];
      got.region = region_t'(m_tuser[1:0]);
      got.saturated = m_tuser[2];
      if (reaction_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result with nothing outstanding: x=%h y=%h z=%h region=%0d sat=%b",
                   $realtime, got.fx, got.fy, got.fz, got.region, got.saturated);
      end else begin
        want = reaction_q.pop_front();
        if (got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz ||
            got.region !== want.region || got.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: mismatch, expected x=%h y=%h z=%h region=%0d sat=%b", $realtime,
                     want.fx, want.fy, want.fz, want.region, want.saturated);
            $display("%t:           actual   x=%h y=%h z=%h region=%0d sat=%b", $realtime,
                     got.fx, got.fy, got.fz, got.region, got.saturated);
          end
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      v.mode = mode_t'(s_tuser[0]);
      v.px = s_tdata[0 +: WORD_W];
      v.py = s_tdata[WORD_W +: WORD_W];
      v.pz = s_tdata[2 * WORD_W +: WORD_W];
      v.gx = s_tdata[3 * WORD_W +: WORD_W];
      v.gy = s_tdata[4 * WORD_W +: WORD_W];
      v.gz = s_tdata[5 * WORD_W +: WORD_W];
      want = contact_reaction(v);
      reaction_q.push_back(want);
      vertices_in++;
      region_count[want.region]++;
      if (want.saturated) clipped++;
    end
  end

  initial begin
    cfg_t   setting;
    longint gain_w, reach, offs;
    int     axis, sign_v, phase, n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset plane is z = 0 with unit normal along z, so d equals pos_z
    gap_pct = 20;
    queue_vertex(MODE_FORWARD, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_vertex(MODE_FORWARD, 32'd5, 32'd7, 32'd65536, '1, '1, '1);
    queue_vertex(MODE_FORWARD, 32'd0, 32'd0, -32'sd65536, 32'd0, 32'd0, 32'd0);
    queue_vertex(MODE_FORWARD, 32'd0, 32'd0, 32'd65537, 32'd0, 32'd0, 32'd0);
    queue_vertex(MODE_FORWARD, 32'd0, 32'd0, -32'sd65537, 32'd0, 32'd0, 32'd0);
    queue_vertex(MODE_FORWARD, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    queue_vertex(MODE_FORWARD, '1, 32'd0, WORD_MIN, '1, '1, '1);
    queue_vertex(MODE_FORWARD, 32'd0, 32'd0, '1, 32'd0, 32'd0, 32'd0);
    queue_vertex(MODE_BACKWARD, 32'd0, 32'd0, 32'd0, WORD_MAX, WORD_MIN, WORD_MAX);
    queue_vertex(MODE_BACKWARD, WORD_MAX, WORD_MIN, 32'd65536, 32'd0, 32'd0, WORD_MIN);
    queue_vertex(MODE_BACKWARD, 32'd0, 32'd0, -32'sd65536, 32'd0, 32'd0, WORD_MAX);
    queue_vertex(MODE_BACKWARD, 32'd0, 32'd0, -32'sd65537, 32'd1, 32'd1, WORD_MIN);
    queue_vertex(MODE_BACKWARD, 32'd0, 32'd0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    queue_vertex(MODE_BACKWARD, 32'd0, 32'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    queue_vertex(MODE_BACKWARD, '1, '1, '1, '1, '1, '1);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: setting = '{GAIN_W'(131072), GAIN_W'(32768), GAIN_W'(65536),
                       NORM_W'(39322), NORM_W'(52429), NORM_W'(0), WORD_W'(-16384)};
        1: setting = '{'1, '1, '1, NORM_W'(-65536), NORM_W'(65536), NORM_W'(-65536), WORD_MAX};
        2: setting = '{GAIN_W'(1), GAIN_W'(1), GAIN_W'(0),
                       NORM_W'(65536), NORM_W'(0), NORM_W'(0), WORD_MIN};
        // zero cutoff and zero gain: the band shrinks to the plane itself
        3: setting = '{GAIN_W'(65536), GAIN_W'(0), GAIN_W'(0),
                       NORM_W'(0), NORM_W'(-65536), NORM_W'(0), WORD_W'(0)};
        default: begin
          setting.stiffness = GAIN_W'($urandom_range(1, 1 << 22));
          setting.cutoff_distance = GAIN_W'($urandom_range(1, 1 << 20));
          gain_w = (longint'(setting.stiffness) << FRAC_BITS) /
                   (4 * longint'(setting.cutoff_distance));
          if (gain_w > 64'h7fff_ffff) gain_w = 64'h7fff_ffff;
          setting.quad_gain = gain_w[GAIN_W-1:0];
          if ($urandom_range(1)) begin
            axis = $urandom_range(2);
            sign_v = $urandom_range(1) ? 65536 : -65536;
            setting.normal_x = NORM_W'((axis == 0) ? sign_v : 0);
            setting.normal_y = NORM_W'((axis == 1) ? sign_v : 0);
            setting.normal_z = NORM_W'((axis == 2) ? sign_v : 0);
          end else begin
            setting.normal_x = NORM_W'(int'($urandom_range(0, 131072)) - 65536);
            setting.normal_y = NORM_W'(int'($urandom_range(0, 131072)) - 65536);
            setting.normal_z = NORM_W'(int'($urandom_range(0, 131072)) - 65536);
          end
          setting.plane_offset = WORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        end
      endcase
      load_plane(setting);

      // the final phase runs at full rate on both sides
      gap_pct = (phase == PHASES - 1) ? 0 : (phase % 3) * 15;
      offs = longint'($signed(setting.plane_offset));
      if (offs < 0) offs = -offs;
      reach = 3 * longint'(setting.cutoff_distance) + offs + 4096;
      if (reach > (64'sd1 << 30)) reach = 64'sd1 << 30;
      for (n = 0; n < VERTICES_PER_PHASE; n++)
        queue_vertex(mode_t'($urandom_range(1)), pick_word(reach), pick_word(reach),
                     pick_word(reach), pick_word(64'sd1 << 18), pick_word(64'sd1 << 18),
                     pick_word(64'sd1 << 18));
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d vertices, forward and backward, under the reset plane and %0d loaded ones.",
             vertices_in, PHASES);
    $display("Regions seen: beyond %0d, band %0d, penetration %0d; %0d results clipped.",
             region_count[REGION_NONE], region_count[REGION_BAND], region_count[REGION_PEN],
             clipped);
    if (mismatches == 0 && reaction_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", reaction_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
